FILE: hw/rtl/lscr_pkg.sv
// ----------------------------------------------------------------------------
// lscr_pkg
// Shared types and constants of the line segment rectangle clipper: outcode
// bit positions, register indexes, reset values and controller interface.
// ----------------------------------------------------------------------------
package lscr_pkg;

  // outcode bit positions
  localparam int unsigned OC_TOP    = 0;
  localparam int unsigned OC_BOTTOM = 1;
  localparam int unsigned OC_RIGHT  = 2;
  localparam int unsigned OC_LEFT   = 3;
  localparam int unsigned OC_BITS   = 4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BOTTOM = 2'd3;

  // window after reset
  localparam int CLIP_LEFT_RST   = 500;
  localparam int CLIP_TOP_RST    = 500;
  localparam int CLIP_RIGHT_RST  = 600;
  localparam int CLIP_BOTTOM_RST = 600;

  // at most this many cuts per segment
  localparam int unsigned CUT_LIMIT = 4;
  localparam int unsigned CUT_BITS  = 3;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // take a new segment
    logic swap;        // exchange the endpoints
    logic mul;         // choose edge, form product and denominator
    logic div_start;   // launch the divider
    logic cut;         // move the endpoint and send the cut piece
    logic emit_final;  // send the remainder as last piece
  } lscr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic accept;      // both outcodes zero
    logic reject;      // outcodes share a bit
    logic c1_zero;     // first endpoint inside
    logic div_busy;    // divider still iterating
  } lscr_status_t;

endpackage

FILE: hw/rtl/lscr_div.sv
// ----------------------------------------------------------------------------
// lscr_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// known to fit in W+1 bits, so only W+1 steps are needed.
// ----------------------------------------------------------------------------
module lscr_div #(
  parameter int unsigned W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2*W+1:0]   dividend_i,
  input  logic [W:0]       divisor_i,
  output logic             busy_o,
  output logic [W:0]       quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(W + 2);

  logic [W:0]          rem_q, rem_d;
  logic [W:0]          quo_q, quo_d;
  logic [W:0]          den_q, den_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [W+1:0]        trial;

  // one restoring step
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[W]};
    if (start_i) begin
      rem_d = dividend_i[2*W+1:W+1];
      quo_d = dividend_i[W:0];
      den_d = divisor_i;
      cnt_d = CNT_BITS'(W + 1);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = (W+1)'(trial - {1'b0, den_q});
        quo_d = {quo_q[W-1:0], 1'b1};
      end else begin
        rem_d = trial[W:0];
        quo_d = {quo_q[W-1:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/lscr_dp.sv
// ----------------------------------------------------------------------------
// lscr_dp
// Clipper datapath: window registers, endpoint registers, outcodes,
// intersection product, divider and result registers.
// ----------------------------------------------------------------------------
module lscr_dp
  import lscr_pkg::*;
#(
  parameter int unsigned W = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lscr_cmd_t               cmd_i,
  output lscr_status_t            status_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [W-1:0]            cfg_data_i,
  input  logic [W-1:0]            x_start_i,
  input  logic [W-1:0]            y_start_i,
  input  logic [W-1:0]            x_end_i,
  input  logic [W-1:0]            y_end_i,
  output logic [W-1:0]            seg_ax_o,
  output logic [W-1:0]            seg_ay_o,
  output logic [W-1:0]            seg_bx_o,
  output logic [W-1:0]            seg_by_o,
  output logic                    visible_o,
  output logic                    last_o,
  output logic                    result_valid_o
);

  logic signed [W-1:0] left_q, top_q, right_q, bottom_q;
  logic signed [W-1:0] x_q, y_q, x1_q, y1_q;
  logic signed [W-1:0] e_q, b_q;
  logic                horiz_q;
  logic signed [2*W+1:0] prod_q;
  logic signed [W:0]   den_q;

  logic [W-1:0] ax_q, ay_q, bx_q, by_q;
  logic         vis_q, last_q, valid_q;

  logic [OC_BITS-1:0] c1, c2;

  function automatic logic [OC_BITS-1:0] outcode(logic signed [W-1:0] px,
                                                 logic signed [W-1:0] py,
                                                 logic signed [W-1:0] l,
                                                 logic signed [W-1:0] t,
                                                 logic signed [W-1:0] r,
                                                 logic signed [W-1:0] bt);
    logic [OC_BITS-1:0] c;
    c            = '0;
    c[OC_TOP]    = (py < t);
    c[OC_BOTTOM] = (py > bt);
    c[OC_RIGHT]  = (px > r);
    c[OC_LEFT]   = (px < l);
    return c;
  endfunction

  // outcodes of both endpoints
  assign c1 = outcode(x_q, y_q, left_q, top_q, right_q, bottom_q);
  assign c2 = outcode(x1_q, y1_q, left_q, top_q, right_q, bottom_q);

  // edge choice and operands of the intersection
  logic signed [W-1:0]   sa, sb, sa1, sb1, se;
  logic                  shoriz;
  logic signed [W:0]     num, dif, den;
  logic signed [2*W+1:0] prod;

  always_comb begin
    sa = x_q; sb = y_q; sa1 = x1_q; sb1 = y1_q; se = top_q; shoriz = 1'b1;
    priority if (c1[OC_LEFT]) begin
      se = left_q; shoriz = 1'b0;
    end else if (c1[OC_RIGHT]) begin
      se = right_q; shoriz = 1'b0;
    end else if (c1[OC_BOTTOM]) begin
      sa = y_q; sb = x_q; sa1 = y1_q; sb1 = x1_q; se = bottom_q;
    end else begin
      sa = y_q; sb = x_q; sa1 = y1_q; sb1 = x1_q; se = top_q;
    end
    num  = $signed({se[W-1], se}) - $signed({sa[W-1], sa});
    dif  = $signed({sb1[W-1], sb1}) - $signed({sb[W-1], sb});
    den  = $signed({sa1[W-1], sa1}) - $signed({sa[W-1], sa});
    prod = num * dif;
  end

  // magnitudes for the divider
  logic [2*W+1:0] prod_abs;
  logic [W:0]     den_abs;
  logic           quo_neg;
  logic           div_busy;
  logic [W:0]     quo;

  assign prod_abs = prod_q[2*W+1] ? (2*W+2)'(-prod_q) : prod_q;
  assign den_abs  = den_q[W] ? (W+1)'(-den_q) : den_q;
  assign quo_neg  = prod_q[2*W+1] ^ den_q[W];

  lscr_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_abs),
    .divisor_i  (den_abs),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // new endpoint from the quotient
  logic signed [W+1:0] step, nb_wide;
  logic signed [W-1:0] nb, nx, ny;

  always_comb begin
    if (den_q == '0) begin
      step = '0;
    end else if (quo_neg) begin
      step = -$signed({1'b0, quo});
    end else begin
      step = $signed({1'b0, quo});
    end
    nb_wide = $signed({{2{b_q[W-1]}}, b_q}) + step;
    nb      = nb_wide[W-1:0];
    nx      = horiz_q ? nb : e_q;
    ny      = horiz_q ? e_q : nb;
  end

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= W'(CLIP_LEFT_RST);
      top_q    <= W'(CLIP_TOP_RST);
      right_q  <= W'(CLIP_RIGHT_RST);
      bottom_q <= W'(CLIP_BOTTOM_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CLIP_LEFT:   left_q   <= cfg_data_i;
        REG_CLIP_TOP:    top_q    <= cfg_data_i;
        REG_CLIP_RIGHT:  right_q  <= cfg_data_i;
        REG_CLIP_BOTTOM: bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // endpoint and intersection registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_start_i; y_q <= y_start_i; x1_q <= x_end_i; y1_q <= y_end_i;
    end else if (cmd_i.swap) begin
      x_q <= x1_q; y_q <= y1_q; x1_q <= x_q; y1_q <= y_q;
    end else if (cmd_i.cut) begin
      x_q <= nx; y_q <= ny;
    end
    if (cmd_i.mul) begin
      e_q     <= se;
      b_q     <= sb;
      horiz_q <= shoriz;
      prod_q  <= prod;
      den_q   <= den;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cut) begin
      ax_q <= x_q; ay_q <= y_q; bx_q <= nx; by_q <= ny;
      vis_q <= 1'b0; last_q <= 1'b0;
    end else if (cmd_i.emit_final) begin
      ax_q <= x_q; ay_q <= y_q; bx_q <= x1_q; by_q <= y1_q;
      vis_q <= (c1 == '0) && (c2 == '0); last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.cut | cmd_i.emit_final;
    end
  end

  assign status_o.accept   = (c1 == '0) && (c2 == '0);
  assign status_o.reject   = |(c1 & c2);
  assign status_o.c1_zero  = (c1 == '0);
  assign status_o.div_busy = div_busy;

  assign seg_ax_o       = ax_q;
  assign seg_ay_o       = ay_q;
  assign seg_bx_o       = bx_q;
  assign seg_by_o       = by_q;
  assign visible_o      = vis_q;
  assign last_o         = last_q;
  assign result_valid_o = valid_q;

endmodule

FILE: hw/rtl/lscr_ctrl.sv
// ----------------------------------------------------------------------------
// lscr_ctrl
// Clipper controller: walks each segment through evaluate, multiply, divide
// and cut steps, and counts the cuts.
// ----------------------------------------------------------------------------
module lscr_ctrl
  import lscr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  lscr_status_t status_i,
  output lscr_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_MUL   = 6'b000100,
    S_DSTRT = 6'b001000,
    S_DWAIT = 6'b010000,
    S_CUT   = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CUT_BITS-1:0] cuts_q, cuts_d;
  logic                done;

  // segment decided or out of cuts
  assign done = status_i.accept | status_i.reject | (cuts_q == CUT_BITS'(CUT_LIMIT));

  // next state and commands
  always_comb begin
    state_d = state_q;
    cuts_d  = cuts_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cuts_d     = '0;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (done) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.swap = status_i.c1_zero;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DSTRT;
      end
      S_DSTRT: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (!status_i.div_busy) begin
          state_d = S_CUT;
        end
      end
      S_CUT: begin
        cmd_o.cut = 1'b1;
        cuts_d    = cuts_q + 1'b1;
        state_d   = S_EVAL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cuts_q  <= '0;
    end else begin
      state_q <= state_d;
      cuts_q  <= cuts_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // cut count stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cuts_q <= CUT_BITS'(CUT_LIMIT))
    else $error("cut count beyond limit");

  // an accepted segment is evaluated next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q == S_EVAL))
    else $error("segment not evaluated after start");

  // final piece always ends the segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_final |=> (state_q == S_IDLE))
    else $error("controller busy after final piece");

  // a cut is only made after the divider finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cut |-> !status_i.div_busy)
    else $error("cut while divider running");

endmodule

FILE: hw/rtl/line_segment_rect_clipper_top.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper_top
// Clips one segment against a configurable rectangle with outcodes, sending
// each cut piece and then the final remainder.
// ----------------------------------------------------------------------------
// A segment is taken when start_i is high and busy_o low. It produces one to
// five results, each shown for a single cycle with result_valid_o; the
// receiver cannot stall, so results must be taken as they come. Each cut
// passes through the evaluate, multiply, divider start, divider wait and cut
// states, the wait lasting while the bit-serial divider iterates; the last
// result is shown in the cycle in which busy_o has fallen. The window
// registers take writes at any time through cfg_valid_i (cfg_ready_o is
// always high) but should only be changed while busy_o is low and no result
// is pending.
module line_segment_rect_clipper_top
  import lscr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [COORD_BITS-1:0]   x_start_i,
  input  logic [COORD_BITS-1:0]   y_start_i,
  input  logic [COORD_BITS-1:0]   x_end_i,
  input  logic [COORD_BITS-1:0]   y_end_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  output logic                    result_valid_o,
  output logic [COORD_BITS-1:0]   seg_ax_o,
  output logic [COORD_BITS-1:0]   seg_ay_o,
  output logic [COORD_BITS-1:0]   seg_bx_o,
  output logic [COORD_BITS-1:0]   seg_by_o,
  output logic                    visible_o,
  output logic                    last_o
);

  lscr_cmd_t    cmd;
  lscr_status_t status;
  logic         busy;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  lscr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lscr_dp #(.W(COORD_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .x_start_i      (x_start_i),
    .y_start_i      (y_start_i),
    .x_end_i        (x_end_i),
    .y_end_i        (y_end_i),
    .seg_ax_o       (seg_ax_o),
    .seg_ay_o       (seg_ay_o),
    .seg_bx_o       (seg_bx_o),
    .seg_by_o       (seg_by_o),
    .visible_o      (visible_o),
    .last_o         (last_o),
    .result_valid_o (result_valid_o)
  );

  assign busy_o = busy;

endmodule

FILE: dv/tb_line_segment_rect_clipper_top.sv
// ----------------------------------------------------------------------------
// tb_line_segment_rect_clipper_top
// Self-checking bench for the outcode segment clipper. A short table of
// segments runs under the reset window first. Random segments then run under a
// series of windows: full range, a single point, two inverted ones and random
// ones. Every piece is checked against an in-bench clipper or a typed result.
// ----------------------------------------------------------------------------
module tb_line_segment_rect_clipper_top
  import lscr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB      = 12;
  localparam int          CMIN    = -2048;
  localparam int          CMAX    = 2047;
  localparam int          SETTLE  = 90;
  localparam int          N_RAND  = 20;

  typedef logic [CB-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, bx, by;
    logic   vis, last;
  } piece_t;

  // directed segment, with a hand-typed single result where obvious
  typedef struct {
    int x0, y0, x1, y1;
    bit typed;
    bit vis;
  } seg_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  coord_t                  x_start_i = '0, y_start_i = '0, x_end_i = '0, y_end_i = '0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = REG_CLIP_LEFT;
  coord_t                  cfg_data_i = '0;
  logic                    result_valid_o;
  coord_t                  seg_ax_o, seg_ay_o, seg_bx_o, seg_by_o;
  logic                    visible_o, last_o;

  line_segment_rect_clipper_top #(.COORD_BITS(CB)) dut (.*);

  always #4 clk_i = ~clk_i;

  // window copy and bookkeeping
  int win_left = CLIP_LEFT_RST, win_top = CLIP_TOP_RST;
  int win_right = CLIP_RIGHT_RST, win_bottom = CLIP_BOTTOM_RST;
  piece_t pending_pieces[$];
  int n_errors, n_segments, n_pieces, n_cuts, n_visible, n_windows;

  // append one expected piece
  function automatic void enqueue_piece(piece_t p);
    pending_pieces = {pending_pieces, p};
  endfunction

  function automatic logic [OC_BITS-1:0] region_code(int x, int y);
    logic [OC_BITS-1:0] c = '0;
    c[OC_TOP]    = y < win_top;
    c[OC_BOTTOM] = y > win_bottom;
    c[OC_RIGHT]  = x > win_right;
    c[OC_LEFT]   = x < win_left;
    return c;
  endfunction

  // point on the segment where axis a reaches e, truncating division
  function automatic int edge_point(int a, int b, int a1, int b1, int e);
    longint den = longint'(a1) - a;
    longint step = 0;
    if (den != 0) step = (longint'(e) - a) * (longint'(b1) - b) / den;
    return int'(longint'(b) + step);
  endfunction

  function automatic piece_t make_piece(int ax, int ay, int bx, int by, logic v, logic l);
    piece_t p;
    p.ax = coord_t'(ax); p.ay = coord_t'(ay);
    p.bx = coord_t'(bx); p.by = coord_t'(by);
    p.vis = v; p.last = l;
    return p;
  endfunction

  // clip one segment and queue every piece it should produce
  function automatic void clip_segment(int x, int y, int x1, int y1);
    logic [OC_BITS-1:0] c1, c2;
    int ox, oy, t;
    for (int k = 0; k < CUT_LIMIT; k++) begin
      c1 = region_code(x, y);
      c2 = region_code(x1, y1);
      if (c1 == 0 && c2 == 0) begin
        enqueue_piece(make_piece(x, y, x1, y1, 1'b1, 1'b1));
        return;
      end
      if ((c1 & c2) != 0) begin
        enqueue_piece(make_piece(x, y, x1, y1, 1'b0, 1'b1));
        return;
      end
      if (c1 == 0) begin
        t = x; x = x1; x1 = t;
        t = y; y = y1; y1 = t;
        c1 = c2;
      end
      ox = x;
      oy = y;
      if (c1[OC_LEFT]) begin
        y = edge_point(x, y, x1, y1, win_left);   x = win_left;
      end else if (c1[OC_RIGHT]) begin
        y = edge_point(x, y, x1, y1, win_right);  x = win_right;
      end else if (c1[OC_BOTTOM]) begin
        x = edge_point(y, x, y1, x1, win_bottom); y = win_bottom;
      end else begin
        x = edge_point(y, x, y1, x1, win_top);    y = win_top;
      end
      enqueue_piece(make_piece(ox, oy, x, y, 1'b0, 1'b0));
    end
    c1 = region_code(x, y);
    c2 = region_code(x1, y1);
    enqueue_piece(make_piece(x, y, x1, y1, (c1 == 0 && c2 == 0), 1'b1));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // result check at each strobe
  always @(posedge clk_i) begin : check_blk
    piece_t w;
    if (rst_ni && result_valid_o) begin
      n_pieces++;
      if (pending_pieces.size() == 0) begin
        report_mismatch("unexpected piece", 1, 0);
      end else begin
        w = pending_pieces.pop_front();
        if (seg_ax_o !== w.ax) report_mismatch("seg_ax", $signed(seg_ax_o), $signed(w.ax));
        if (seg_ay_o !== w.ay) report_mismatch("seg_ay", $signed(seg_ay_o), $signed(w.ay));
        if (seg_bx_o !== w.bx) report_mismatch("seg_bx", $signed(seg_bx_o), $signed(w.bx));
        if (seg_by_o !== w.by) report_mismatch("seg_by", $signed(seg_by_o), $signed(w.by));
        if (visible_o !== w.vis) report_mismatch("visible", visible_o, w.vis);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
        if (!w.last) n_cuts++;
        if (w.vis) n_visible++;
      end
    end
  end

  // stop sending, wait until every piece is in and the block has gone quiet
  task automatic drain();
    start_i <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_window_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
    cfg_index_i <= idx;
    cfg_data_i  <= coord_t'(val);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CLIP_LEFT:  win_left   = val;
      REG_CLIP_TOP:   win_top    = val;
      REG_CLIP_RIGHT: win_right  = val;
      default:        win_bottom = val;
    endcase
  endtask

  task automatic set_window(int l, int t, int r, int b);
    drain();
    write_window_reg(REG_CLIP_LEFT, l);
    write_window_reg(REG_CLIP_TOP, t);
    write_window_reg(REG_CLIP_RIGHT, r);
    write_window_reg(REG_CLIP_BOTTOM, b);
    n_windows++;
  endtask

  // one segment transaction; start stays high when no gap follows
  task automatic send_segment(int x0, int y0, int x1, int y1, bit typed, bit vis,
                              bit hold_off);
    int gap;
    if (hold_off) begin
      start_i <= 1'b0;
      while (pending_pieces.size() != 0) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    x_start_i <= coord_t'(x0);
    y_start_i <= coord_t'(y0);
    x_end_i   <= coord_t'(x1);
    y_end_i   <= coord_t'(y1);
    do @(posedge clk_i); while (busy_o);
    n_segments++;
    if (typed) enqueue_piece(make_piece(x0, y0, x1, y1, vis, 1'b1));
    else clip_segment(x0, y0, x1, y1);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick(int lo, int hi);
    if (lo < CMIN) lo = CMIN;
    if (hi > CMAX) hi = CMAX;
    if (hi < lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // random segment, mostly around the current window
  task automatic random_segment(bit hold_off);
    int lo_x, hi_x, lo_y, hi_y, x0, y0, x1, y1;
    lo_x = ((win_left < win_right) ? win_left : win_right) - 300;
    hi_x = ((win_left < win_right) ? win_right : win_left) + 300;
    lo_y = ((win_top < win_bottom) ? win_top : win_bottom) - 300;
    hi_y = ((win_top < win_bottom) ? win_bottom : win_top) + 300;
    case ($urandom_range(9))
      0, 1, 2: begin
        x0 = pick(CMIN, CMAX); y0 = pick(CMIN, CMAX);
        x1 = pick(CMIN, CMAX); y1 = pick(CMIN, CMAX);
      end
      3: begin
        x0 = pick(lo_x, hi_x); y0 = pick(lo_y, hi_y);
        x1 = $urandom_range(1) ? x0 : pick(lo_x, hi_x);
        y1 = (x1 == x0) ? pick(lo_y, hi_y) : y0;
      end
      default: begin
        x0 = pick(lo_x, hi_x); y0 = pick(lo_y, hi_y);
        x1 = pick(lo_x, hi_x); y1 = pick(lo_y, hi_y);
      end
    endcase
    send_segment(x0, y0, x1, y1, 1'b0, 1'b0, hold_off);
  endtask

  seg_row_t dir_rows[] = '{
    '{550, 550, 560, 560, 1'b1, 1'b1},       // wholly inside
    '{500, 500, 500, 500, 1'b1, 1'b1},       // point on the low corner
    '{600, 600, 600, 600, 1'b1, 1'b1},       // point on the high corner
    '{0, 0, 100, 900, 1'b1, 1'b0},           // both left
    '{CMIN, CMIN, CMIN, CMAX, 1'b1, 1'b0},   // left, extremes
    '{CMAX, CMAX, CMAX, CMIN, 1'b1, 1'b0},   // right, extremes
    '{CMIN, CMAX, CMAX, CMAX, 1'b1, 1'b0},   // bottom, extremes
    '{CMIN, CMIN, CMAX, CMIN, 1'b1, 1'b0},   // top, extremes
    '{400, 550, 700, 550, 1'b0, 1'b0},       // left then right cut
    '{550, 550, 700, 580, 1'b0, 1'b0},       // inside first, swapped
    '{550, 0, 550, 1000, 1'b0, 1'b0},        // top and bottom cuts
    '{CMIN, CMIN, CMAX, CMAX, 1'b0, 1'b0},   // full diagonal
    '{CMAX, CMIN, CMIN, CMAX, 1'b0, 1'b0},   // reverse diagonal
    '{450, 650, 650, 450, 1'b0, 1'b0},       // corner crossing, many cuts
    '{499, 499, 601, 602, 1'b0, 1'b0},       // truncation near corners
    '{450, 520, 520, 450, 1'b0, 1'b0},       // clips past the corner
    '{560, 400, 700, 580, 1'b0, 1'b0}        // top then right
  };

  // limit on the whole run
  initial begin
    #5ms;
    $display("[line_segment_rect_clipper_top] ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset window
    foreach (dir_rows[i])
      send_segment(dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].x1, dir_rows[i].y1,
                   dir_rows[i].typed, dir_rows[i].vis, 1'b0);

    // random phases over a range of windows
    set_window(CMIN, CMIN, CMAX, CMAX);
    repeat (N_RAND) random_segment(1'b0);
    set_window(0, 0, 0, 0);
    repeat (N_RAND) random_segment(1'b0);
    set_window(600, 600, 500, 500);
    repeat (N_RAND) random_segment(1'b1);
    set_window(CMAX, CMAX, CMIN, CMIN);
    repeat (10) random_segment(1'b0);
    repeat (3) begin
      int l, t;
      l = pick(CMIN, 1800);
      t = pick(CMIN, 1800);
      set_window(l, t, pick(l, l + 400), pick(t, t + 400));
      repeat (N_RAND) random_segment(1'b0);
    end
    start_i <= 1'b0;

    drain();
    $display("covered %0d segments over %0d windows: %0d pieces, %0d cuts, %0d visible",
             n_segments, n_windows + 1, n_pieces, n_cuts, n_visible);
    $display("checks raised %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("[line_segment_rect_clipper_top] OK");
    end else begin
      $display("[line_segment_rect_clipper_top] ERROR");
    end
    $finish;
  end

endmodule
